FILE: design/cpt_pkg.sv
// shared types and constants for the cascaded prescaled timer block
// no dependencies; imported by cpt_cell, cpt_out_buf and cascaded_prescaled_timers
package cpt_pkg;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_WCTL  = 2'd1,
		ACT_WRLD  = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	localparam int CNT_W = 16;
	localparam int CTL_W = 8;
	localparam int PSC_W = 11;

	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	// control byte layout
	localparam int CTL_EN_BIT   = 7;
	localparam int CTL_IRQ_BIT  = 6;
	localparam int CTL_CASC_BIT = 2;

	localparam int FLAG_W = 4;
	localparam int OUT_W  = 24;

	// per-cell command decoded from one input word
	typedef struct packed {
		logic             tick;
		logic             wr_ctl;
		logic             wr_rld;
		logic [CNT_W-1:0] value;
	} cell_cmd_t;

	// prescale period for the two select bits: 1, 64, 256, 1024 ticks
	function automatic logic [PSC_W-1:0] prescale_period(input logic [1:0] sel);
		logic [PSC_W-1:0] per;
		case (sel)
			2'd0:    per = 11'd1;
			2'd1:    per = 11'd64;
			2'd2:    per = 11'd256;
			default: per = 11'd1024;
		endcase
		return per;
	endfunction

endpackage

FILE: design/cpt_cell.sv
// one timer cell: counter, reload, control byte, prescale count and overflow flag
// depends on cpt_pkg; chained by cascaded_prescaled_timers through the cascade input
module cpt_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cpt_pkg::cell_cmd_t        cmd,
	input  logic                      casc_in,
	output logic                      casc_out,
	output logic                      irq,
	output logic                      ovf_next,
	output logic [cpt_pkg::CNT_W-1:0] count
);
	import cpt_pkg::*;

	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] rld_q, rld_d;
	logic [CTL_W-1:0] ctl_q, ctl_d;
	logic [PSC_W-1:0] psc_q, psc_d;
	logic             seen_q, seen_d;
	logic             ovf_q, ovf_d;

	logic             en;
	logic             step;
	logic             wrap;
	logic [CNT_W-1:0] cnt_base;
	logic [PSC_W-1:0] per;
	logic [PSC_W-1:0] psc_base;

	assign en  = ctl_q[CTL_EN_BIT];
	assign per = prescale_period(ctl_q[1:0]);

	always_comb begin
		cnt_d    = cnt_q;
		rld_d    = rld_q;
		ctl_d    = ctl_q;
		psc_d    = psc_q;
		seen_d   = seen_q;
		ovf_d    = ovf_q;
		step     = 1'b0;
		wrap     = 1'b0;
		psc_base = psc_q;
		// enable edge loads the reload value before stepping
		cnt_base = (en && !seen_q) ? rld_q : cnt_q;
		if (cmd.wr_ctl) begin
			ctl_d = cmd.value[CTL_W-1:0];
		end
		if (cmd.wr_rld) begin
			rld_d = cmd.value;
		end
		if (cmd.tick) begin
			seen_d = en;
			cnt_d  = cnt_base;
			if (en) begin
				if (ctl_q[CTL_CASC_BIT]) begin
					step = casc_in;
				end else if (psc_q >= per) begin
					psc_base = psc_q - per;
					step     = 1'b1;
				end
				wrap  = step && (cnt_base == CNT_MAX);
				ovf_d = wrap;
				if (wrap) begin
					cnt_d = rld_q;
				end else if (step) begin
					cnt_d = cnt_base + 1'b1;
				end
				psc_d = psc_base + 1'b1;
			end
		end
	end

	assign casc_out = wrap;
	assign irq      = wrap && ctl_q[CTL_IRQ_BIT];
	assign ovf_next = ovf_d;
	assign count    = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rld_q  <= '0;
			ctl_q  <= '0;
			psc_q  <= '0;
			seen_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			rld_q  <= rld_d;
			ctl_q  <= ctl_d;
			psc_q  <= psc_d;
			seen_q <= seen_d;
			ovf_q  <= ovf_d;
		end
	end

endmodule

FILE: design/cpt_out_buf.sv
// two-entry output buffer, keeps input accepted while one result waits
// depends on cpt_pkg for the result word width
module cpt_out_buf (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [cpt_pkg::OUT_W-1:0] in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [cpt_pkg::OUT_W-1:0] out_data
);
	import cpt_pkg::*;

	logic [OUT_W-1:0] head_q, tail_q;
	logic [1:0]       fill_q;
	logic             push, pop;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign out_data  = head_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else begin
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (fill_q == 2'd2) begin
				head_q <= tail_q;
			end else if (push) begin
				head_q <= in_data;
			end
		end else if (push) begin
			if (fill_q == 2'd0) begin
				head_q <= in_data;
			end else begin
				tail_q <= in_data;
			end
		end
	end

endmodule

FILE: design/cascaded_prescaled_timers.sv
// cascaded prescaled timers: a row of 16-bit timer cells, overflow ripples cell to cell
// result: one result word per input word, registered in the output buffer
// throughput: one word per cycle unless the buffer is full; the cascade ripple through all cells settles in that cycle
// a two-entry output buffer keeps input flowing while one result waits downstream
// reset: arst_n clears all counters, reload values, control bytes and flags at once
// depends on cpt_pkg, cpt_cell and cpt_out_buf
module cascaded_prescaled_timers #(
	parameter int NUM_TIMERS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] write_value
	input  logic [15:0] s_axis_tdata,
	// [1:0] action, [3:2] timer_index
	input  logic [3:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] read_data, [19:16] irq_pulses, [23:20] overflow_flags
	output logic [23:0] m_axis_tdata
);
	import cpt_pkg::*;

	logic [1:0]       action;
	logic [1:0]       timer_index;
	logic [CNT_W-1:0] write_value;
	logic             take;

	assign action      = s_axis_tuser[1:0];
	assign timer_index = s_axis_tuser[3:2];
	assign write_value = s_axis_tdata;
	assign take        = s_axis_tvalid && s_axis_tready;

	// cascade chain: link[i] feeds cell i, timer 0 never sees a cascade step
	logic [NUM_TIMERS:0]   link;
	logic [NUM_TIMERS-1:0] irq_vec;
	logic [NUM_TIMERS-1:0] ovf_vec;
	logic [CNT_W-1:0]      cnt_vec [NUM_TIMERS];

	assign link[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
			cell_cmd_t cmd;
			logic      sel;

			// only indexes below NUM_TIMERS address a cell
			assign sel        = (32'(timer_index) == gi);
			assign cmd.tick   = take && (action == ACT_TICK);
			assign cmd.wr_ctl = take && (action == ACT_WCTL) && sel;
			assign cmd.wr_rld = take && (action == ACT_WRLD) && sel;
			assign cmd.value  = write_value;

			cpt_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.casc_in  (link[gi]),
				.casc_out (link[gi+1]),
				.irq      (irq_vec[gi]),
				.ovf_next (ovf_vec[gi]),
				.count    (cnt_vec[gi])
			);
		end
	endgenerate

	// read mux, zero for other actions or an unpopulated index
	logic [CNT_W-1:0] read_data;
	always_comb begin
		read_data = '0;
		if (action == ACT_READ) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (32'(timer_index) == i) begin
					read_data = cnt_vec[i];
				end
			end
		end
	end

	// only the first four timers report pulses and flags
	logic [FLAG_W-1:0] irq_pulses;
	logic [FLAG_W-1:0] overflow_flags;
	generate
		for (gi = 0; gi < FLAG_W; gi++) begin : g_flag
			if (gi < NUM_TIMERS) begin : g_on
				assign irq_pulses[gi]     = irq_vec[gi];
				assign overflow_flags[gi] = ovf_vec[gi];
			end else begin : g_off
				assign irq_pulses[gi]     = 1'b0;
				assign overflow_flags[gi] = 1'b0;
			end
		end
	endgenerate

	// result word is built from the state as it stands after this input word
	logic [OUT_W-1:0] result;
	assign result = {overflow_flags, irq_pulses, read_data};

	cpt_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (result),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

FILE: verif/cascaded_prescaled_timers_tb.sv
// self-checking testbench for cascaded_prescaled_timers: directed and random words, random stalls
// depends on cpt_pkg and the cascaded_prescaled_timers rtl; no files, no arguments
module cascaded_prescaled_timers_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cpt_pkg::*;

	localparam int N_TMR        = 4;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	// control byte fields
	localparam logic [7:0] CTL_EN   = 8'h80;
	localparam logic [7:0] CTL_IRQ  = 8'h40;
	localparam logic [7:0] CTL_CASC = 8'h04;

	// prescale select codes
	localparam logic [1:0] PSC_DIV1    = 2'd0;
	localparam logic [1:0] PSC_DIV64   = 2'd1;
	localparam logic [1:0] PSC_DIV256  = 2'd2;
	localparam logic [1:0] PSC_DIV1024 = 2'd3;

	// result word, read_data in the low bits
	typedef struct packed {
		logic [3:0]  ovf_flags;
		logic [3:0]  irq_pulses;
		logic [15:0] read_data;
	} timer_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [15:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tready = 1'b0;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [23:0] m_axis_tdata;

	// predicted timer state
	logic [15:0] tmr_count  [N_TMR];
	logic [15:0] tmr_reload [N_TMR];
	logic [7:0]  tmr_ctl    [N_TMR];
	logic        tmr_en_seen[N_TMR];
	logic [10:0] tmr_psc    [N_TMR];
	logic        tmr_ovf    [N_TMR];

	timer_result_t expected_words[$];

	int  words_sent = 0;
	int  err_count = 0;
	int  cycle_count = 0;
	bit  src_idle_on = 1'b1;
	bit  sink_idle_on = 1'b1;

	cascaded_prescaled_timers #(
		.NUM_TIMERS(N_TMR)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// applies one word to the predicted state and returns the expected result word
	function automatic timer_result_t predict_timer_word(action_t act, logic [1:0] idx,
			logic [15:0] val);
		timer_result_t res;
		logic [7:0]  ctl;
		logic [10:0] per;
		logic        en, step, ovf_now, prev_ovf;
		res = '0;
		prev_ovf = 1'b0;
		case (act)
			ACT_TICK: begin
				// timers visited in order so an overflow ripples up the chain in one tick
				for (int i = 0; i < N_TMR; i++) begin
					ctl = tmr_ctl[i];
					en = ctl[CTL_EN_BIT];
					ovf_now = 1'b0;
					if (en && !tmr_en_seen[i])
						tmr_count[i] = tmr_reload[i];
					tmr_en_seen[i] = en;
					if (en) begin
						step = 1'b0;
						if (ctl[CTL_CASC_BIT]) begin
							// timer 0 has nothing upstream
							step = (i != 0) && prev_ovf;
						end else begin
							case (ctl[1:0])
								PSC_DIV1:   per = 11'd1;
								PSC_DIV64:  per = 11'd64;
								PSC_DIV256: per = 11'd256;
								default:    per = 11'd1024;
							endcase
							if (tmr_psc[i] >= per) begin
								tmr_psc[i] = tmr_psc[i] - per;
								step = 1'b1;
							end
						end
						tmr_ovf[i] = 1'b0;
						if (step) begin
							if (tmr_count[i] == CNT_MAX) begin
								tmr_ovf[i] = 1'b1;
								ovf_now = 1'b1;
								tmr_count[i] = tmr_reload[i];
								if (ctl[CTL_IRQ_BIT])
									res.irq_pulses[i] = 1'b1;
							end else begin
								tmr_count[i] = tmr_count[i] + 16'd1;
							end
						end
						// prescaler runs in both modes, 11-bit wrap
						tmr_psc[i] = tmr_psc[i] + 11'd1;
					end
					prev_ovf = ovf_now;
				end
			end
			ACT_WCTL: tmr_ctl[idx] = val[7:0];
			ACT_WRLD: tmr_reload[idx] = val;
			default:  res.read_data = tmr_count[idx];
		endcase
		for (int i = 0; i < 4; i++)
			res.ovf_flags[i] = tmr_ovf[i];
		return res;
	endfunction

	// presents one word, waits for the handshake, then records its expected result
	task automatic send_word(action_t act, logic [1:0] idx, logic [15:0] val);
		if (src_idle_on && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= val;
		s_tuser <= {idx, act};
		do @(posedge clk); while (!s_axis_tready);
		expected_words.push_back(predict_timer_word(act, idx, val));
		words_sent++;
	endtask

	// downstream ready with random stall bursts
	initial begin
		forever begin
			@(posedge clk);
			if (sink_idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic report_mismatch(string what, timer_result_t want, timer_result_t got);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t %s: want rd=%h irq=%b ovf=%b, got rd=%h irq=%b ovf=%b", $realtime,
				what, want.read_data, want.irq_pulses, want.ovf_flags,
				got.read_data, got.irq_pulses, got.ovf_flags);
	endtask

	// result word check against the oldest expectation
	always @(posedge clk) begin : result_check
		timer_result_t got, want;
		if (arst_n && m_axis_tvalid && m_tready) begin
			got = m_axis_tdata;
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", '0, got);
			end else begin
				want = expected_words.pop_front();
				if (got.read_data !== want.read_data || got.irq_pulses !== want.irq_pulses ||
						got.ovf_flags !== want.ovf_flags)
					report_mismatch("word mismatch", want, got);
			end
		end
	end

	// counters read back as zero out of reset
	task automatic test_reset_reads();
		for (int i = 0; i < N_TMR; i++)
			send_word(ACT_READ, i[1:0], 16'($urandom));
	endtask

	// reload extremes, and a control write whose upper byte must be dropped
	task automatic test_register_access();
		send_word(ACT_WRLD, 2'd0, 16'hFFFE);
		send_word(ACT_WRLD, 2'd1, 16'hFFFF);
		send_word(ACT_WRLD, 2'd2, 16'hFFFF);
		send_word(ACT_WRLD, 2'd3, 16'h0000);
		send_word(ACT_WCTL, 2'd3, 16'hFF3F);
		send_word(ACT_READ, 2'd3, 16'hFFFF);
	endtask

	// enable edge load, prescale-by-one stepping, overflow rippling through the cascade,
	// timer 0 in cascade mode, and a disabled timer holding its value
	task automatic test_enable_and_cascade();
		send_word(ACT_WCTL, 2'd0, {8'hA5, CTL_EN | CTL_IRQ | {6'd0, PSC_DIV1}});
		send_word(ACT_WCTL, 2'd1, {8'h5A, CTL_EN | CTL_IRQ | CTL_CASC});
		send_word(ACT_WCTL, 2'd2, {8'h00, CTL_EN | CTL_CASC | {6'd0, PSC_DIV1024}});
		send_word(ACT_WCTL, 2'd3, {8'hFF, CTL_EN | CTL_IRQ | CTL_CASC});
		repeat (4) send_word(ACT_TICK, 2'd0, 16'h0000);
		send_word(ACT_READ, 2'd3, 16'h0000);
		send_word(ACT_READ, 2'd0, 16'h0000);
		send_word(ACT_WCTL, 2'd0, {8'h00, CTL_EN | CTL_CASC | {6'd0, PSC_DIV64}});
		repeat (2) send_word(ACT_TICK, 2'd3, 16'hFFFF);
		send_word(ACT_READ, 2'd0, 16'h0000);
		send_word(ACT_WCTL, 2'd1, 16'h0000);
		send_word(ACT_TICK, 2'd1, 16'h0000);
		send_word(ACT_READ, 2'd1, 16'h0000);
	endtask

	// mostly well-formed programming sequences followed by tick runs, plus raw noise
	task automatic test_random_traffic(int n_words);
		int          first;
		logic [15:0] rld;
		logic [7:0]  ctl;
		logic [1:0]  psc;
		first = words_sent;
		while (words_sent - first < n_words) begin
			if ($urandom_range(0, 3) != 0) begin
				// park every timer so the next enable is a fresh edge
				for (int i = 0; i < N_TMR; i++)
					send_word(ACT_WCTL, i[1:0], {8'($urandom_range(0, 255)), 1'b0,
						7'($urandom_range(0, 127))});
				// skipping the arming tick makes a broken sequence now and then
				if ($urandom_range(0, 5) != 0)
					send_word(ACT_TICK, 2'($urandom), 16'($urandom));
				for (int i = 0; i < N_TMR; i++) begin
					case ($urandom_range(0, 3))
						0:       rld = 16'($urandom);
						3:       rld = 16'(16'hFFFF - $urandom_range(0, 255));
						default: rld = 16'(16'hFFFF - $urandom_range(0, 3));
					endcase
					send_word(ACT_WRLD, i[1:0], rld);
					case ($urandom_range(0, 19))
						0:                     psc = PSC_DIV1024;
						1, 2, 3:               psc = PSC_DIV256;
						4, 5, 6, 7, 8, 9:      psc = PSC_DIV64;
						default:               psc = PSC_DIV1;
					endcase
					ctl = {($urandom_range(0, 7) != 0), 1'($urandom), 3'($urandom), 1'b0, psc};
					if (i == 0 ? $urandom_range(0, 7) == 0 : $urandom_range(0, 2) != 0)
						ctl = ctl | CTL_CASC;
					send_word(ACT_WCTL, i[1:0], {8'($urandom_range(0, 255)), ctl});
				end
				repeat ($urandom_range(20, 150)) begin
					case ($urandom_range(0, 19))
						0, 1:    send_word(ACT_READ, 2'($urandom), 16'($urandom));
						2:       send_word(ACT_WCTL, 2'($urandom), 16'($urandom));
						default: send_word(ACT_TICK, 2'($urandom), 16'($urandom));
					endcase
				end
			end else begin
				repeat ($urandom_range(5, 30))
					send_word(action_t'($urandom_range(0, 3)), 2'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < N_TMR; i++) begin
			tmr_count[i] = '0;
			tmr_reload[i] = '0;
			tmr_ctl[i] = '0;
			tmr_en_seen[i] = 1'b0;
			tmr_psc[i] = '0;
			tmr_ovf[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_reads();
		test_register_access();
		test_enable_and_cascade();
		test_random_traffic(1300);
		// last stretch runs back to back on both sides
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		test_random_traffic(200);
		s_tvalid <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_words.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
design/cpt_pkg.sv
design/cpt_cell.sv
design/cpt_out_buf.sv
design/cascaded_prescaled_timers.sv
verif/cascaded_prescaled_timers_tb.sv
